>>> hw/rtl/sitd_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
package sitd_pkg;

  // Input value width and character width
  localparam int unsigned ValW  = 32;
  localparam int unsigned CharW = 8;

  // Decimal digits: at most ten for a 32-bit magnitude
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned IdxW      = $clog2(MaxDigits);

  // Divide by ten through a reciprocal: q = (x * RecipMul) >> RecipShift
  localparam int unsigned  ProdW      = 2 * ValW;
  localparam int unsigned  RecipShift = 35;
  localparam int unsigned  QuotW      = ProdW - RecipShift;
  localparam logic [ValW-1:0] RecipMul = 32'hCCCC_CCCD;

  // Character codes
  localparam logic [CharW-1:0] CodeZero  = 8'd48;
  localparam logic [CharW-1:0] CodeMinus = 8'd45;

  // Job queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // One classified item: sign and unsigned magnitude
  typedef struct packed {
    logic            neg;
    logic [ValW-1:0] mag;
  } job_t;

endpackage

>>> hw/rtl/sitd_ifs.sv
// Valid/ready channel interfaces for the value input and the character output.
interface sitd_in_if;
  import sitd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitd_out_if;
  import sitd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> hw/rtl/sitd_front.sv
// Front end: accepts input beats and splits each value into sign and magnitude.
module sitd_front (
  sitd_in_if.sink          in_i,
  output sitd_pkg::job_t   job_o,
  output logic             job_valid_o,
  input  logic             job_ready_i
);
  import sitd_pkg::*;

  logic [ValW-1:0] raw;

  // Sign bit and two's complement magnitude, taken unsigned
  always_comb begin
    raw       = in_i.value;
    job_o.neg = raw[ValW-1];
    job_o.mag = raw[ValW-1] ? (~raw + {{(ValW-1){1'b0}}, 1'b1}) : raw;
  end

  assign job_valid_o = in_i.valid;
  assign in_i.ready  = job_ready_i;

endmodule

>>> hw/rtl/sitd_queue.sv
// Short job queue that decouples the front end from the digit back end.
module sitd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sitd_pkg::job_t  push_data_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output sitd_pkg::job_t  pop_data_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);
  import sitd_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/sitd_back.sv
// Back end: peels decimal digits by reciprocal divide, then emits the characters.
module sitd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sitd_pkg::job_t  job_i,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  sitd_out_if.source      out_o
);
  import sitd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUB, ST_EMIT} state_e;

  state_e              state_q;
  logic [ValW-1:0]     mag_q;
  logic                neg_q;
  logic [QuotW-1:0]    quot_q;
  logic [IdxW-1:0]     cnt_q;
  logic [IdxW-1:0]     idx_q;
  logic                sign_pend_q;
  logic [DigitW-1:0]   digits_q [MaxDigits];
  logic                ovalid_q;
  logic [CharW-1:0]    char_q;
  logic                last_q;

  logic [ProdW-1:0]    prod;
  logic [ValW-1:0]     quot_ext;
  logic [ValW-1:0]     times10;
  logic [ValW-1:0]     rem_full;
  logic                slot_free;

  // Reciprocal multiply, registered before the remainder step
  assign prod = {{ValW{1'b0}}, mag_q} * {{ValW{1'b0}}, RecipMul};

  // Remainder: x - 10*q, always below ten
  always_comb begin
    quot_ext = {{(ValW-QuotW){1'b0}}, quot_q};
    times10  = (quot_ext << 3) + (quot_ext << 1);
    rem_full = mag_q - times10;
  end

  assign slot_free   = !ovalid_q || out_o.ready;
  assign job_ready_o = (state_q == ST_IDLE);

  assign out_o.valid     = ovalid_q;
  assign out_o.char_code = char_q;
  assign out_o.last_char = last_q;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ovalid_q    <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      sign_pend_q <= 1'b0;
    end else begin
      // Output beat: load on an emit, drop once taken
      if (state_q == ST_EMIT && slot_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            mag_q   <= job_i.mag;
            neg_q   <= job_i.neg;
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          quot_q  <= prod[ProdW-1:RecipShift];
          state_q <= ST_SUB;
        end
        ST_SUB: begin
          digits_q[cnt_q] <= rem_full[DigitW-1:0];
          mag_q           <= quot_ext;
          cnt_q           <= cnt_q + 1'b1;
          if (quot_q == '0) begin
            idx_q       <= cnt_q;
            sign_pend_q <= neg_q;
            state_q     <= ST_EMIT;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (sign_pend_q) begin
              char_q      <= CodeMinus;
              last_q      <= 1'b0;
              sign_pend_q <= 1'b0;
            end else begin
              char_q <= CodeZero + {{(CharW-DigitW){1'b0}}, digits_q[idx_q]};
              last_q <= (idx_q == '0);
              if (idx_q == '0) begin
                state_q <= ST_IDLE;
              end else begin
                idx_q <= idx_q - 1'b1;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text. Each input beat carries one
// signed value; the block returns its decimal text as a run of output beats,
// one character each: '-' first for a negative value, then the digits most
// significant first with no leading zeros ("0" for zero), the last beat
// flagged by last_char. The most negative value renders as "-2147483648".
// A two-entry job queue sits between input and converter, so new values are
// taken while a previous one is still being converted or emitted. Conversion
// loads the item, then takes one multiply-by-reciprocal step and one remainder
// step per digit; the characters then follow at one character per cycle when
// the output is not stalled. Reset clears all control state; no clearing pass
// is needed.
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  sitd_in_if.sink     in_i,
  sitd_out_if.source  out_o
);
  import sitd_pkg::*;

  job_t front_job, back_job;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  sitd_front u_front (
    .in_i        (in_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  sitd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  sitd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

>>> hw/rtl/sitd_checker.sv
// Port-level checks for the decimal text converter, bound to the top level.
module sitd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [sitd_pkg::CharW-1:0]  out_char_i,
  input logic                        out_last_i
);
  import sitd_pkg::*;

  // No output beat is offered while reset is applied
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // A stalled output beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_char_i) && $stable(out_last_i))
    else $error("stalled output beat changed");

  // Only a minus sign or a decimal digit is ever emitted
  a_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_char_i == CodeMinus) ||
      (out_char_i >= CodeZero && out_char_i <= CodeZero + 8'd9))
    else $error("character outside sign and digit codes");

  // The sign never ends a run, and an accepted sign is never directly followed by another
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_char_i == CodeMinus |-> !out_last_i)
    else $error("minus sign flagged as last character");

  a_no_double_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_char_i == CodeMinus ##1 out_valid_i |->
      out_char_i != CodeMinus)
    else $error("two minus signs in a row");

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.char_code),
  .out_last_i  (out_o.last_char)
);
